>>> hw/rtl/s2c_cov_pkg.sv
// Shared types and constants for the spherical to Cartesian covariance block.
// Used by s2c_sin and spherical_to_cartesian_covariance_top. No dependencies.
package s2c_cov_pkg;

    localparam int TRIG_PRECISION_BITS = 18;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [28:0] KQ      = 29'd334930395;

    localparam int HORNER_STEPS = 7;
    localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{210, 156, 110, 72, 42, 20, 6};

    // three setup stages, three per series step, two to finish
    localparam int SIN_LATENCY = 3 + 3 * HORNER_STEPS + 2;

    localparam int DIAG_W = 47;
    localparam int OFFD_W = 48;

    typedef struct packed {
        logic        [23:0] range_m;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic        [31:0] range_variance;
        logic        [31:0] azimuth_variance;
        logic        [31:0] elevation_variance;
    } t_in_word;

    typedef struct packed {
        logic        [DIAG_W-1:0] cov_xx;
        logic signed [OFFD_W-1:0] cov_xy;
        logic signed [OFFD_W-1:0] cov_xz;
        logic        [DIAG_W-1:0] cov_yy;
        logic signed [OFFD_W-1:0] cov_yz;
        logic        [DIAG_W-1:0] cov_zz;
        logic                     saturated;
    } t_out_word;

endpackage

>>> hw/rtl/s2c_mul.sv
// Pipelined unsigned multiplier built from 32x32 partial products.
// Two register stages: partial products, then their sum. No dependencies.
module s2c_mul #(
    parameter int WA = 48,
    parameter int WB = 48
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [WA-1:0]   i_a,
    input  logic [WB-1:0]   i_b,
    output logic [WA+WB-1:0] o_p
);
    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int SW = 32 * (NA + NB);

    logic [NA*32-1:0] w_a;
    logic [NB*32-1:0] w_b;
    logic [63:0]      r_pp [NA*NB];
    logic [SW-1:0]    n_sum;
    logic [WA+WB-1:0] r_p;

    always_comb begin
        w_a = '0;
        w_a[WA-1:0] = i_a;
        w_b = '0;
        w_b[WB-1:0] = i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= 64'(w_a[32*i +: 32]) * 64'(w_b[32*j +: 32]);
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SW'(r_pp[i*NB+j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[WA+WB-1:0];
        end
    end

    assign o_p = r_p;
endmodule

>>> hw/rtl/s2c_sin.sv
// Pipelined sine of a 16-bit binary angle, Taylor series in Q30 by Horner steps.
// Depends on s2c_cov_pkg.
module s2c_sin #(
    parameter int P = s2c_cov_pkg::TRIG_PRECISION_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [P+1:0] o_sin
);
    localparam int W  = P + 2;
    localparam int HS = s2c_cov_pkg::HORNER_STEPS;
    localparam int SH = 30 - P;
    localparam logic [31:0] H = (32'd1 << SH) >> 1;
    localparam logic [62:0] HALF30 = 63'd1 << 29;

    logic [1:0]  w_q;
    logic [14:0] w_arg;
    logic [46:0] r_prod;
    logic        r_neg1;
    logic [30:0] w_x;
    logic [30:0] r_x2s;
    logic [61:0] r_xx;
    logic        r_neg2;

    logic [30:0] r_cx   [3*HS+1];
    logic [31:0] r_cx2  [3*HS+1];
    logic        r_cneg [3*HS+1];

    logic [62:0] r_mp [HS];
    logic [31:0] r_v  [HS];
    logic [30:0] r_q0 [HS];
    logic [30:0] r_t  [HS];

    logic [61:0] r_st;
    logic        r_negf;
    logic [30:0] w_s;
    logic [30:0] w_sc;
    logic [31:0] w_sp;
    logic signed [W-1:0] w_pos;
    logic signed [W-1:0] r_sin;

    assign w_q   = i_angle[15:14];
    assign w_arg = w_q[0] ? (15'd16384 - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
    assign w_x   = 31'((r_prod + 47'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= 47'(w_arg) * 47'(s2c_cov_pkg::PI_Q30);
            r_neg1    <= w_q[1];
            r_x2s     <= w_x;
            r_xx      <= 62'(w_x) * 62'(w_x);
            r_neg2    <= r_neg1;
            r_cx[0]   <= r_x2s;
            r_cx2[0]  <= 32'((63'(r_xx) + HALF30) >> 30);
            r_cneg[0] <= r_neg2;
        end
    end

    for (genvar i = 0; i < HS; i++) begin : g_step
        localparam logic [31:0] K = 32'(s2c_cov_pkg::HORNER_DIV[i]);
        localparam logic [63:0] M = (64'd1 << 33) / 64'(K);
        logic [30:0] w_tin;
        logic [31:0] w_rem;
        logic [30:0] w_qt;

        if (i == 0) begin : g_first
            assign w_tin = s2c_cov_pkg::ONE_Q30;
        end else begin : g_next
            assign w_tin = r_t[i-1];
        end

        assign w_rem = r_v[i] - (32'(r_q0[i]) * K);
        assign w_qt  = (w_rem >= K) ? (r_q0[i] + 31'd1) : r_q0[i];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mp[i] <= 63'(r_cx2[3*i]) * 63'(w_tin);
                r_v[i]  <= r_mp[i][61:30];
                r_q0[i] <= 31'((64'(r_mp[i][61:30]) * M) >> 33);
                r_t[i]  <= s2c_cov_pkg::ONE_Q30 - w_qt;
                for (int s = 1; s <= 3; s++) begin
                    r_cx[3*i+s]   <= r_cx[3*i+s-1];
                    r_cx2[3*i+s]  <= r_cx2[3*i+s-1];
                    r_cneg[3*i+s] <= r_cneg[3*i+s-1];
                end
            end
        end
    end

    assign w_s   = 31'((63'(r_st) + HALF30) >> 30);
    assign w_sc  = (w_s > s2c_cov_pkg::ONE_Q30) ? s2c_cov_pkg::ONE_Q30 : w_s;
    assign w_sp  = (32'(w_sc) + H) >> SH;
    assign w_pos = {1'b0, w_sp[P:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st   <= 62'(r_cx[3*HS]) * 62'(r_t[HS-1]);
            r_negf <= r_cneg[3*HS];
            r_sin  <= r_negf ? -w_pos : w_pos;
        end
    end

    assign o_sin = r_sin;
endmodule

>>> hw/rtl/spherical_to_cartesian_covariance_top.sv
// Top level: spherical to Cartesian position covariance of one radar measurement.
// Depends on s2c_cov_pkg, s2c_sin and s2c_mul.
//
// Usage:
//   Input channel i_in_valid / o_in_ready / i_in_word carries one measurement
//   word (range, azimuth, elevation, three variances). Output channel
//   o_out_valid / i_out_ready / o_out_word carries the six unique entries of the
//   3x3 position covariance plus a saturation flag. One output word per input.
//   The sine series pipeline (26 stages) is followed by the rotation,
//   variance scaling and covariance products, each wide product split over
//   two multiplier stages. Throughput is one word per cycle while not held.
//   The whole pipeline advances together; it holds when the output register is
//   full and the receiver is not ready, so o_in_ready drops in that case and no
//   word is lost or repeated. Synchronous reset clears all valid bits; the
//   block is ready right after reset.
module spherical_to_cartesian_covariance_top #(
    parameter int P = s2c_cov_pkg::TRIG_PRECISION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  s2c_cov_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output s2c_cov_pkg::t_out_word o_out_word
);
    localparam int SL  = s2c_cov_pkg::SIN_LATENCY;
    localparam int LAT = SL + 13;
    localparam int IDL = SL + 6;
    localparam int W   = P + 2;
    localparam int PW  = 2 * W;
    localparam int CCW = 2 * P + 1;
    localparam int MW  = 2 * P + 1;
    localparam int DW  = 48;
    localparam int KW  = 61;
    localparam int AW  = 2 * P + 50;
    localparam int RW  = AW - 2 * P;
    localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};
    localparam logic signed [PW-1:0] HALF_U = PW'(1) << (P - 1);
    localparam logic signed [AW-1:0] HALF_A = AW'(1) << (2 * P - 1);
    localparam logic signed [RW-1:0] C_MAX  = RW'(47'h7FFF_FFFF_FFFF);
    localparam logic signed [RW-1:0] C_MIN  = -C_MAX - RW'(1);

    logic              w_en;
    logic [LAT-1:0]    r_vld;
    s2c_cov_pkg::t_in_word r_in_d [IDL];

    logic [15:0]       w_az_cos;
    logic [15:0]       w_el_cos;
    logic signed [W-1:0] w_ca, w_sa, w_ce, w_se;

    // c1
    logic signed [PW-1:0] r_ca_ce, r_sa_ce, r_ca_se, r_sa_se, r_cc;
    logic signed [W-1:0]  r_ca1, r_sa1, r_ce1, r_se1;
    logic [47:0]          r_rr;
    logic [KW-1:0]        r_evk;
    // c2
    logic signed [W-1:0]  r_u [3][3];
    // c3
    logic signed [PW-1:0] r_w [6][3];
    logic [47+CCW:0]      w_prc;
    logic [47+KW:0]       w_pd2;
    // c4
    logic [47:0]          r_rc;
    logic [KW-1:0]        r_avk;
    logic [DW-1:0]        r_d2 [3];
    logic [MW-1:0]        r_wmag [3][6][3];
    logic                 r_wneg [6][6][3];
    logic [48+CCW:0]      w_rc_sum;
    logic [48+KW:0]       w_d2_sum;
    // c7
    logic [47+KW:0]       w_pd1;
    logic [48+KW:0]       w_d1_sum;
    logic [DW-1:0]        r_d [3];
    logic [MW-1:0]        r_wm7 [6][3];
    // c9 .. c12
    logic [MW+DW-1:0]     w_tp [6][3];
    logic signed [AW-1:0] r_term [6][3];
    logic signed [AW-1:0] r_acc [6];
    logic signed [RW-1:0] r_rnd [6];
    s2c_cov_pkg::t_out_word r_out;
    s2c_cov_pkg::t_out_word n_out;

    function automatic logic signed [W-1:0] rnd_q(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] s;
        logic signed [PW-1:0] sh;
        s  = v + HALF_U;
        sh = s >>> P;
        return sh[W-1:0];
    endfunction

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_word  = r_out;

    assign w_az_cos = 16'(i_in_word.azimuth) + 16'h4000;
    assign w_el_cos = 16'(i_in_word.elevation) + 16'h4000;

    s2c_sin #(.P(P)) u_sin_ca (.i_clk(i_clk), .i_en(w_en), .i_angle(w_az_cos), .o_sin(w_ca));
    s2c_sin #(.P(P)) u_sin_sa (.i_clk(i_clk), .i_en(w_en),
                               .i_angle(16'(i_in_word.azimuth)), .o_sin(w_sa));
    s2c_sin #(.P(P)) u_sin_ce (.i_clk(i_clk), .i_en(w_en), .i_angle(w_el_cos), .o_sin(w_ce));
    s2c_sin #(.P(P)) u_sin_se (.i_clk(i_clk), .i_en(w_en),
                               .i_angle(16'(i_in_word.elevation)), .o_sin(w_se));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // r*r*cos^2, r*r*EV*KQ and r*r*cos^2*AV*KQ
    s2c_mul #(.WA(48), .WB(CCW)) u_mul_rc (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rr), .i_b(r_cc[CCW-1:0]), .o_p(w_prc)
    );
    s2c_mul #(.WA(48), .WB(KW)) u_mul_d2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rr), .i_b(r_evk), .o_p(w_pd2)
    );
    s2c_mul #(.WA(48), .WB(KW)) u_mul_d1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rc), .i_b(r_avk), .o_p(w_pd1)
    );

    for (genvar n = 0; n < 6; n++) begin : g_ent
        for (genvar k = 0; k < 3; k++) begin : g_term
            s2c_mul #(.WA(MW), .WB(DW)) u_mul_t (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_wm7[n][k]), .i_b(r_d[k]), .o_p(w_tp[n][k])
            );
        end
    end

    assign w_rc_sum = {1'b0, w_prc} + ((49 + CCW)'(1) << (2 * P - 1));
    assign w_d2_sum = {1'b0, w_pd2} + ((49 + KW)'(1) << 63);
    assign w_d1_sum = {1'b0, w_pd1} + ((49 + KW)'(1) << 63);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_d[0] <= i_in_word;
            for (int s = 1; s < IDL; s++) begin
                r_in_d[s] <= r_in_d[s-1];
            end

            // c1
            r_ca_ce <= w_ca * w_ce;
            r_sa_ce <= w_sa * w_ce;
            r_ca_se <= w_ca * w_se;
            r_sa_se <= w_sa * w_se;
            r_cc    <= w_ce * w_ce;
            r_ca1   <= w_ca;
            r_sa1   <= w_sa;
            r_ce1   <= w_ce;
            r_se1   <= w_se;
            r_rr    <= 48'(r_in_d[SL-1].range_m) * 48'(r_in_d[SL-1].range_m);
            r_evk   <= KW'(r_in_d[SL-1].elevation_variance) * KW'(s2c_cov_pkg::KQ);

            // c2
            r_u[0][0] <= rnd_q(r_ca_ce);
            r_u[0][1] <= -r_sa1;
            r_u[0][2] <= -rnd_q(r_ca_se);
            r_u[1][0] <= rnd_q(r_sa_ce);
            r_u[1][1] <= r_ca1;
            r_u[1][2] <= -rnd_q(r_sa_se);
            r_u[2][0] <= r_se1;
            r_u[2][1] <= '0;
            r_u[2][2] <= r_ce1;

            // c3
            for (int n = 0; n < 6; n++) begin
                for (int k = 0; k < 3; k++) begin
                    r_w[n][k] <= r_u[PAIR_I[n]][k] * r_u[PAIR_J[n]][k];
                end
            end

            // c4
            r_rc    <= w_rc_sum[2*P +: 48];
            r_avk   <= KW'(r_in_d[SL+2].azimuth_variance) * KW'(s2c_cov_pkg::KQ);
            r_d2[0] <= DW'(w_d2_sum[48+KW:64]);
            for (int s = 1; s < 3; s++) begin
                r_d2[s] <= r_d2[s-1];
            end
            for (int n = 0; n < 6; n++) begin
                for (int k = 0; k < 3; k++) begin
                    r_wneg[0][n][k] <= r_w[n][k][PW-1];
                    r_wmag[0][n][k] <= r_w[n][k][PW-1] ? MW'(-r_w[n][k]) : MW'(r_w[n][k]);
                    for (int s = 1; s < 3; s++) begin
                        r_wmag[s][n][k] <= r_wmag[s-1][n][k];
                    end
                    for (int s = 1; s < 6; s++) begin
                        r_wneg[s][n][k] <= r_wneg[s-1][n][k];
                    end
                end
            end

            // c7
            r_d[0] <= DW'(r_in_d[SL+5].range_variance);
            r_d[1] <= DW'(w_d1_sum[48+KW:64]);
            r_d[2] <= r_d2[2];
            for (int n = 0; n < 6; n++) begin
                for (int k = 0; k < 3; k++) begin
                    r_wm7[n][k] <= r_wmag[2][n][k];
                end
            end

            // c10 .. c12
            for (int n = 0; n < 6; n++) begin
                for (int k = 0; k < 3; k++) begin
                    r_term[n][k] <= r_wneg[5][n][k] ? -$signed(AW'(w_tp[n][k]))
                                                    : $signed(AW'(w_tp[n][k]));
                end
                r_acc[n] <= r_term[n][0] + r_term[n][1] + r_term[n][2];
                r_rnd[n] <= RW'((r_acc[n] + HALF_A) >>> (2 * P));
            end

            // c13
            r_out <= n_out;
        end
    end

    always_comb begin
        logic signed [RW-1:0] v;
        logic signed [RW-1:0] c [6];
        logic sat;
        sat = 1'b0;
        for (int n = 0; n < 6; n++) begin
            v = r_rnd[n];
            if (PAIR_I[n] == PAIR_J[n]) begin
                if (v < 0) begin
                    c[n] = '0;
                    sat  = 1'b1;
                end else if (v > C_MAX) begin
                    c[n] = C_MAX;
                    sat  = 1'b1;
                end else begin
                    c[n] = v;
                end
            end else begin
                if (v < C_MIN) begin
                    c[n] = C_MIN;
                    sat  = 1'b1;
                end else if (v > C_MAX) begin
                    c[n] = C_MAX;
                    sat  = 1'b1;
                end else begin
                    c[n] = v;
                end
            end
        end
        n_out.cov_xx    = c[0][s2c_cov_pkg::DIAG_W-1:0];
        n_out.cov_xy    = c[1][s2c_cov_pkg::OFFD_W-1:0];
        n_out.cov_xz    = c[2][s2c_cov_pkg::OFFD_W-1:0];
        n_out.cov_yy    = c[3][s2c_cov_pkg::DIAG_W-1:0];
        n_out.cov_yz    = c[4][s2c_cov_pkg::OFFD_W-1:0];
        n_out.cov_zz    = c[5][s2c_cov_pkg::DIAG_W-1:0];
        n_out.saturated = sat;
    end
endmodule
